// ===== rtl/mfr_pkg.sv =====
// Shared types, constants and the verdict function of the mirror frame rewriter.
package mfr_pkg;

    localparam int WORD_BYTES     = 8;
    localparam int DATA_W         = 64;
    localparam int CNT_W          = 4;
    localparam int TDATA_W        = 72;
    localparam int HOLD_WORDS_DEF = 12;
    localparam int MAX_OUT_DEF    = 2048;
    localparam int HDR_BYTES      = 38;
    localparam int POS_W          = 8;
    localparam int NW_W           = 5;
    localparam int IDX_W          = 12;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int PREFIX_LEN     = 5;

    localparam logic [IDX_W-1:0] IDX_MAX        = 12'hfff;
    localparam logic [39:0]      TZSP_PREFIX    = 40'h01_01_00_00_01;
    localparam logic [15:0]      ET_IPV4        = 16'h0800;
    localparam logic [15:0]      ET_VLAN        = 16'h8100;
    localparam logic [15:0]      COLLECTOR_PORT = 16'd37008;
    localparam logic [7:0]       PROTO_UDP      = 8'd17;
    localparam logic [7:0]       IP_OFF_V4      = 8'd14;
    localparam logic [7:0]       IP_OFF_VLAN    = 8'd18;
    localparam logic [POS_W-1:0] MIN_FRAME      = 8'd12;
    localparam logic [POS_W-1:0] TZSP_MIN       = 8'd34;
    localparam logic [POS_W-1:0] VLAN_IP_END    = 8'd38;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_TEE  = 2'd1;
    localparam logic [1:0] MODE_TZSP = 2'd2;

    localparam logic [1:0] CFG_MODE       = 2'd0;
    localparam logic [1:0] CFG_REMOTE_MAC = 2'd1;
    localparam logic [1:0] CFG_SENDER_MAC = 2'd2;
    localparam logic [1:0] CFG_TARGET_IP  = 2'd3;

    typedef enum logic [2:0] {V_OPEN, V_DROP, V_PLAIN, V_TZSP, V_TEE} verdict_t;
    typedef enum logic [1:0] {F_OPEN, F_DROP, F_FWD} front_state_t;
    typedef enum logic [1:0] {B_HEAD, B_RAM, B_STREAM, B_FLUSH} back_state_t;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] remote_mac;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
    } cfg_t;

    typedef struct packed {
        logic              replay;
        logic              tzsp;
        logic              tee;
        logic [NW_W-1:0]   nwords;
        logic [DATA_W-1:0] tail_data;
        logic [CNT_W-1:0]  tail_cnt;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic replay_done;
    } bk_status_t;

    // UDP destination port offset: IP start + 4*IHL + 2
    function automatic logic [7:0] port_offset(hdr_t h);
        logic       vlan;
        logic [3:0] ihl;
        vlan = ({h[12], h[13]} == ET_VLAN);
        ihl  = vlan ? h[18][3:0] : h[14][3:0];
        return (vlan ? IP_OFF_VLAN : IP_OFF_V4) + {2'b00, ihl, 2'b00} + 8'd2;
    endfunction

    function automatic verdict_t decide(logic [POS_W-1:0] n, logic is_final, cfg_t cfg,
                                        hdr_t h, logic [15:0] dport);
        logic [15:0] et;
        logic        vlan;
        logic [31:0] dest;
        logic [7:0]  proto;
        logic [7:0]  po;
        logic        mac_eq;
        verdict_t    v;
        et     = {h[12], h[13]};
        vlan   = (et == ET_VLAN);
        dest   = vlan ? {h[34], h[35], h[36], h[37]} : {h[30], h[31], h[32], h[33]};
        proto  = vlan ? h[27] : h[23];
        po     = port_offset(h);
        mac_eq = ({h[0], h[1], h[2], h[3], h[4], h[5]} == cfg.remote_mac);
        if (n <= MIN_FRAME) begin
            v = is_final ? V_DROP : V_OPEN;
        end else if (cfg.mode == MODE_PASS) begin
            v = V_PLAIN;
        end else if (cfg.mode == MODE_TEE) begin
            v = mac_eq ? V_DROP : V_TEE;
        end else if (cfg.mode != MODE_TZSP) begin
            v = V_DROP;
        end else if (n <= TZSP_MIN) begin
            v = is_final ? V_DROP : V_OPEN;
        end else if (et != ET_IPV4 && et != ET_VLAN) begin
            v = V_DROP;
        end else if (vlan && n < VLAN_IP_END) begin
            v = is_final ? V_TZSP : V_OPEN;
        end else if (dest != cfg.target_ip || proto != PROTO_UDP) begin
            v = V_TZSP;
        end else if (n < po + 8'd2) begin
            v = is_final ? V_TZSP : V_OPEN;
        end else begin
            v = (dport == COLLECTOR_PORT) ? V_DROP : V_TZSP;
        end
        return v;
    endfunction

endpackage

// ===== rtl/mirror_frame_rewriter.sv =====
// Top level of the mirror frame rewriter: configuration registers and the front/back pipeline.
// Streamed words after the verdict pass at one word per cycle unless queue or output stall;
// the word that completes an output word passes the command queue, then the output register.
// At the verdict the held header is replayed word by word from the hold RAM's registered read port,
// and the next frame's first word waits until that replay is done.
// aresetn is synchronous, active low: clears control state and the configuration registers.
module mirror_frame_rewriter #(
    parameter int HOLD_WORDS    = mfr_pkg::HOLD_WORDS_DEF,
    parameter int MAX_OUT_BYTES = mfr_pkg::MAX_OUT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mfr_pkg::TDATA_W-1:0] s_tdata,   // data[63:0], count[67:64], zero pad
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mfr_pkg::TDATA_W-1:0] m_tdata,   // out_data[63:0], out_count[67:64], zero pad
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [47:0]                 cfg_wr_data
);
    mfr_pkg::cfg_t                  cfg_reg;
    mfr_pkg::bk_status_t            status;
    mfr_pkg::q_entry_t              push_entry, head;
    logic                           q_push, q_pop, q_full, q_valid;
    logic                           ram_we;
    logic [$clog2(HOLD_WORDS)-1:0]  ram_waddr, ram_raddr;
    logic [mfr_pkg::DATA_W-1:0]     ram_wdata, ram_rdata;
    logic [mfr_pkg::DATA_W-1:0]     m_data;
    logic [mfr_pkg::CNT_W-1:0]      m_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mfr_pkg::CFG_MODE:       cfg_reg.mode       <= cfg_wr_data[1:0];
                mfr_pkg::CFG_REMOTE_MAC: cfg_reg.remote_mac <= cfg_wr_data;
                mfr_pkg::CFG_SENDER_MAC: cfg_reg.sender_mac <= cfg_wr_data;
                mfr_pkg::CFG_TARGET_IP:  cfg_reg.target_ip  <= cfg_wr_data[31:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    mfr_front #(.HOLD_WORDS(HOLD_WORDS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata[63:0]),
        .s_count   (s_tdata[67:64]),
        .s_last    (s_tlast),
        .cfg       (cfg_reg),
        .status    (status),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    mfr_ram #(.WIDTH(mfr_pkg::DATA_W), .DEPTH(HOLD_WORDS)) u_hold (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head)
    );

    mfr_back #(.HOLD_WORDS(HOLD_WORDS), .MAX_OUT_BYTES(MAX_OUT_BYTES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_entry   (head),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .status    (status),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_data),
        .m_count   (m_count),
        .m_last    (m_tlast)
    );

    assign m_tdata = {4'b0000, m_count, m_data};
endmodule

// ===== rtl/mfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/mfr_front.sv =====
// Front end: accepts words, packs the header into the hold RAM and reaches the verdict.
module mfr_front #(
    parameter int HOLD_WORDS = mfr_pkg::HOLD_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mfr_pkg::DATA_W-1:0]     s_data,
    input  logic [mfr_pkg::CNT_W-1:0]      s_count,
    input  logic                           s_last,
    input  mfr_pkg::cfg_t                  cfg,
    input  mfr_pkg::bk_status_t            status,
    input  logic                           q_full,
    output logic                           q_push,
    output mfr_pkg::q_entry_t              q_entry,
    output logic                           ram_we,
    output logic [$clog2(HOLD_WORDS)-1:0]  ram_waddr,
    output logic [mfr_pkg::DATA_W-1:0]     ram_wdata
);
    localparam int WI_W       = $clog2(HOLD_WORDS + 1);
    localparam int AW         = $clog2(HOLD_WORDS);
    localparam int HOLD_BYTES = HOLD_WORDS * mfr_pkg::WORD_BYTES;

    mfr_pkg::front_state_t             st_reg, st_next;
    logic [WI_W-1:0]                   widx_reg, widx_next;
    logic [mfr_pkg::DATA_W-1:0]        pend_reg, pend_next;
    logic [2:0]                        pcnt_reg, pcnt_next;
    mfr_pkg::hdr_t                     hdr_reg, hdr_n;
    logic [15:0]                       pb_reg, pb_n;
    logic                              lock_reg;

    logic                              accept;
    logic [mfr_pkg::CNT_W-1:0]         k;
    logic [mfr_pkg::DATA_W-1:0]        dmask;
    logic [mfr_pkg::POS_W-1:0]         pos, n_new;
    logic                              ovf;
    logic [2*mfr_pkg::DATA_W-1:0]      comb;
    logic [4:0]                        tot;
    logic                              full_w;
    logic [7:0]                        po;
    mfr_pkg::verdict_t                 vd_hold, vd_ovf, vd;
    logic                              fwd;

    assign s_ready = !q_full && !(st_reg == mfr_pkg::F_OPEN && lock_reg);
    assign accept  = s_valid && s_ready;

    assign k   = (s_count > 4'd8) ? 4'd8 : s_count;
    assign pos = mfr_pkg::POS_W'({widx_reg, pcnt_reg});
    assign n_new = pos + mfr_pkg::POS_W'(k);
    assign ovf = ({1'b0, pos} + 9'(k)) > 9'(HOLD_BYTES);

    always_comb begin
        for (int i = 0; i < mfr_pkg::WORD_BYTES; i++) begin
            dmask[8*i +: 8] = (4'(i) < k) ? s_data[8*i +: 8] : 8'h00;
        end
    end

    assign comb   = {64'b0, pend_reg} | ({64'b0, dmask} << {pcnt_reg, 3'b000});
    assign tot    = {2'b00, pcnt_reg} + {1'b0, k};
    assign full_w = (tot >= 5'd8);

    // header bytes at fixed places, including the word now arriving
    always_comb begin
        logic [mfr_pkg::POS_W-1:0] lp;
        hdr_n = hdr_reg;
        for (int i = 0; i < mfr_pkg::WORD_BYTES; i++) begin
            lp = pos + mfr_pkg::POS_W'(i);
            if (4'(i) < k && lp < mfr_pkg::POS_W'(mfr_pkg::HDR_BYTES)) begin
                hdr_n[lp[5:0]] = dmask[8*i +: 8];
            end
        end
    end

    assign po = mfr_pkg::port_offset(hdr_n);

    always_comb begin
        logic [mfr_pkg::POS_W-1:0] lp;
        pb_n = pb_reg;
        for (int i = 0; i < mfr_pkg::WORD_BYTES; i++) begin
            lp = pos + mfr_pkg::POS_W'(i);
            if (4'(i) < k && lp == po) begin
                pb_n[15:8] = dmask[8*i +: 8];
            end
            if (4'(i) < k && lp == po + 8'd1) begin
                pb_n[7:0] = dmask[8*i +: 8];
            end
        end
    end

    assign vd_hold = mfr_pkg::decide(n_new, s_last, cfg, hdr_n, pb_n);
    assign vd_ovf  = mfr_pkg::decide(pos, 1'b1, cfg, hdr_reg, pb_reg);
    assign vd      = ovf ? vd_ovf : vd_hold;
    assign fwd     = (vd == mfr_pkg::V_PLAIN) || (vd == mfr_pkg::V_TZSP) ||
                     (vd == mfr_pkg::V_TEE);

    assign widx_next = full_w ? widx_reg + WI_W'(1) : widx_reg;
    assign pend_next = full_w ? comb[127:64] : comb[63:0];
    assign pcnt_next = full_w ? 3'(tot - 5'd8) : tot[2:0];

    // next state
    always_comb begin
        st_next = st_reg;
        if (accept) begin
            if (s_last) begin
                st_next = mfr_pkg::F_OPEN;
            end else if (st_reg == mfr_pkg::F_OPEN) begin
                if (vd == mfr_pkg::V_DROP) begin
                    st_next = mfr_pkg::F_DROP;
                end else if (fwd) begin
                    st_next = mfr_pkg::F_FWD;
                end
            end
        end
    end

    // queue and hold RAM writes
    always_comb begin
        q_push    = 1'b0;
        q_entry   = '0;
        ram_we    = 1'b0;
        ram_waddr = widx_reg[AW-1:0];
        ram_wdata = comb[63:0];
        if (accept) begin
            case (st_reg)
                mfr_pkg::F_OPEN: begin
                    q_entry.replay = 1'b1;
                    q_entry.tzsp   = (vd == mfr_pkg::V_TZSP);
                    q_entry.tee    = (vd == mfr_pkg::V_TEE);
                    q_entry.last   = s_last;
                    if (ovf) begin
                        q_entry.nwords    = mfr_pkg::NW_W'(widx_reg);
                        q_entry.tail_data = pend_reg;
                        q_entry.tail_cnt  = {1'b0, pcnt_reg};
                        q_entry.data      = dmask;
                        q_entry.cnt       = k;
                    end else begin
                        ram_we            = full_w;
                        q_entry.nwords    = mfr_pkg::NW_W'(widx_next);
                        q_entry.tail_data = pend_next;
                        q_entry.tail_cnt  = {1'b0, pcnt_next};
                    end
                    q_push = fwd;
                end
                mfr_pkg::F_FWD: begin
                    q_push       = 1'b1;
                    q_entry.data = dmask;
                    q_entry.cnt  = k;
                    q_entry.last = s_last;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= mfr_pkg::F_OPEN;
            widx_reg <= '0;
            pcnt_reg <= '0;
            pend_reg <= '0;
            lock_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (accept && s_last) begin
                widx_reg <= '0;
                pcnt_reg <= '0;
                pend_reg <= '0;
            end else if (accept && st_reg == mfr_pkg::F_OPEN && !ovf) begin
                widx_reg <= widx_next;
                pcnt_reg <= pcnt_next;
                pend_reg <= pend_next;
            end
            if (q_push && q_entry.replay) begin
                lock_reg <= 1'b1;
            end else if (status.replay_done) begin
                lock_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && st_reg == mfr_pkg::F_OPEN && !ovf) begin
            hdr_reg  <= hdr_n;
            pb_reg   <= pb_n;
        end
    end
endmodule

// ===== rtl/mfr_queue.sv =====
// Short command queue between the front end and the back end.
module mfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mfr_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output mfr_pkg::q_entry_t head
);
    mfr_pkg::q_entry_t          mem [mfr_pkg::QUEUE_DEPTH];
    logic [mfr_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [mfr_pkg::QPTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (mfr_pkg::QPTR_W+1)'(mfr_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_entry;
        end
    end
endmodule

// ===== rtl/mfr_back.sv =====
// Back end: replays held header bytes, rewrites them and repacks into full output words.
module mfr_back #(
    parameter int HOLD_WORDS    = mfr_pkg::HOLD_WORDS_DEF,
    parameter int MAX_OUT_BYTES = mfr_pkg::MAX_OUT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  mfr_pkg::q_entry_t              q_entry,
    output logic                           q_pop,
    input  mfr_pkg::cfg_t                  cfg,
    output mfr_pkg::bk_status_t            status,
    output logic [$clog2(HOLD_WORDS)-1:0]  ram_raddr,
    input  logic [mfr_pkg::DATA_W-1:0]     ram_rdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mfr_pkg::DATA_W-1:0]     m_data,
    output logic [mfr_pkg::CNT_W-1:0]      m_count,
    output logic                           m_last
);
    localparam int WI_W = $clog2(HOLD_WORDS + 1);
    localparam int AW   = $clog2(HOLD_WORDS);
    localparam logic [mfr_pkg::IDX_W-1:0] LIMIT =
        mfr_pkg::IDX_W'(MAX_OUT_BYTES - mfr_pkg::PREFIX_LEN);

    mfr_pkg::back_state_t         st_reg, st_next;
    logic [WI_W-1:0]              widx_reg;
    logic                         primed_reg;
    logic [mfr_pkg::DATA_W-1:0]   carry_reg;
    logic [mfr_pkg::CNT_W-1:0]    ccnt_reg;
    logic [mfr_pkg::IDX_W-1:0]    idx_reg;
    logic                         tzsp_reg, tee_reg;
    logic                         m_valid_reg, m_last_reg;
    logic [mfr_pkg::DATA_W-1:0]   m_data_reg;
    logic [mfr_pkg::CNT_W-1:0]    m_cnt_reg;

    logic                         do_step, indexed, ram_end;
    logic [mfr_pkg::DATA_W-1:0]   src_bytes, sb;
    logic [mfr_pkg::CNT_W-1:0]    src_k, kk;
    logic [mfr_pkg::IDX_W-1:0]    rem;
    logic [11:0][7:0]             tee_b;
    logic [2*mfr_pkg::DATA_W-1:0] comb;
    logic [4:0]                   tot;
    logic                         emit, out_free, go, go_flush;
    logic [mfr_pkg::IDX_W:0]      idx_sum;
    logic [mfr_pkg::IDX_W-1:0]    idx_new;

    assign out_free  = !m_valid_reg || m_ready;
    assign ram_end   = (mfr_pkg::NW_W'(widx_reg) == q_entry.nwords);
    assign ram_raddr = widx_reg[AW-1:0];

    // pick the bytes merged this cycle
    always_comb begin
        do_step   = 1'b0;
        indexed   = 1'b1;
        src_bytes = q_entry.data;
        src_k     = q_entry.cnt;
        case (st_reg)
            mfr_pkg::B_HEAD: begin
                if (q_valid && q_entry.replay) begin
                    do_step   = q_entry.tzsp;
                    indexed   = 1'b0;
                    src_bytes = {24'b0, mfr_pkg::TZSP_PREFIX};
                    src_k     = mfr_pkg::CNT_W'(mfr_pkg::PREFIX_LEN);
                end else begin
                    do_step = q_valid;
                end
            end
            mfr_pkg::B_RAM: begin
                if (ram_end) begin
                    do_step   = 1'b1;
                    src_bytes = q_entry.tail_data;
                    src_k     = q_entry.tail_cnt;
                end else begin
                    do_step   = primed_reg;
                    src_bytes = ram_rdata;
                    src_k     = 4'd8;
                end
            end
            mfr_pkg::B_STREAM: begin
                do_step = 1'b1;
            end
            default: begin
                do_step = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            tee_b[j]     = cfg.remote_mac[47-8*j -: 8];
            tee_b[j + 6] = cfg.sender_mac[47-8*j -: 8];
        end
    end

    // truncation past the output limit in TZSP frames
    assign rem = (idx_reg >= LIMIT) ? '0 : LIMIT - idx_reg;
    assign kk  = (tzsp_reg && indexed && rem < mfr_pkg::IDX_W'(src_k)) ? rem[3:0] : src_k;

    always_comb begin
        logic [mfr_pkg::IDX_W:0] lp;
        for (int j = 0; j < mfr_pkg::WORD_BYTES; j++) begin
            lp = {1'b0, idx_reg} + (mfr_pkg::IDX_W+1)'(j);
            if (4'(j) >= kk) begin
                sb[8*j +: 8] = 8'h00;
            end else if (indexed && tee_reg && lp < 13'd12) begin
                sb[8*j +: 8] = tee_b[lp[3:0]];
            end else begin
                sb[8*j +: 8] = src_bytes[8*j +: 8];
            end
        end
    end

    assign comb    = {64'b0, carry_reg} | ({64'b0, sb} << {ccnt_reg, 3'b000});
    assign tot     = {1'b0, ccnt_reg} + {1'b0, kk};
    assign emit    = (tot > 5'd8);
    assign go      = do_step && (!emit || out_free);
    assign go_flush = (st_reg == mfr_pkg::B_FLUSH) && (ccnt_reg == '0 || out_free);
    assign idx_sum = {1'b0, idx_reg} + (mfr_pkg::IDX_W+1)'(src_k);
    assign idx_new = !indexed ? idx_reg :
                     (idx_sum > {1'b0, mfr_pkg::IDX_MAX}) ? mfr_pkg::IDX_MAX :
                     idx_sum[mfr_pkg::IDX_W-1:0];

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            mfr_pkg::B_HEAD: begin
                if (q_valid && q_entry.replay) begin
                    if (!q_entry.tzsp || go) begin
                        st_next = mfr_pkg::B_RAM;
                    end
                end else if (go && q_entry.last) begin
                    st_next = mfr_pkg::B_FLUSH;
                end
            end
            mfr_pkg::B_RAM: begin
                if (ram_end && go) begin
                    st_next = mfr_pkg::B_STREAM;
                end
            end
            mfr_pkg::B_STREAM: begin
                if (go) begin
                    st_next = q_entry.last ? mfr_pkg::B_FLUSH : mfr_pkg::B_HEAD;
                end
            end
            mfr_pkg::B_FLUSH: begin
                if (go_flush) begin
                    st_next = mfr_pkg::B_HEAD;
                end
            end
            default: begin
                st_next = mfr_pkg::B_HEAD;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        q_pop              = 1'b0;
        status.replay_done = 1'b0;
        case (st_reg)
            mfr_pkg::B_HEAD: begin
                q_pop = q_valid && !q_entry.replay && go && !q_entry.last;
            end
            mfr_pkg::B_RAM: begin
                status.replay_done = ram_end && go;
            end
            mfr_pkg::B_STREAM: begin
                q_pop = go && !q_entry.last;
            end
            mfr_pkg::B_FLUSH: begin
                q_pop = go_flush;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= mfr_pkg::B_HEAD;
            widx_reg    <= '0;
            primed_reg  <= 1'b0;
            carry_reg   <= '0;
            ccnt_reg    <= '0;
            idx_reg     <= '0;
            tzsp_reg    <= 1'b0;
            tee_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == mfr_pkg::B_HEAD && st_next == mfr_pkg::B_RAM) begin
                tzsp_reg   <= q_entry.tzsp;
                tee_reg    <= q_entry.tee;
                widx_reg   <= '0;
                primed_reg <= 1'b0;
            end else if (st_reg == mfr_pkg::B_RAM && !ram_end) begin
                if (!primed_reg) begin
                    primed_reg <= 1'b1;
                end else if (go) begin
                    primed_reg <= 1'b0;
                    widx_reg   <= widx_reg + WI_W'(1);
                end
            end
            if (go) begin
                carry_reg <= emit ? comb[127:64] : comb[63:0];
                ccnt_reg  <= emit ? 4'(tot - 5'd8) : tot[3:0];
                idx_reg   <= idx_new;
            end else if (go_flush) begin
                carry_reg <= '0;
                ccnt_reg  <= '0;
                idx_reg   <= '0;
                tzsp_reg  <= 1'b0;
                tee_reg   <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= (go && emit) || (go_flush && ccnt_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (go_flush) begin
                m_data_reg <= carry_reg;
                m_cnt_reg  <= ccnt_reg;
                m_last_reg <= 1'b1;
            end else begin
                m_data_reg <= comb[63:0];
                m_cnt_reg  <= 4'd8;
                m_last_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_count = m_cnt_reg;
    assign m_last  = m_last_reg;
endmodule

// ===== rtl/mfr_checker.sv =====
// Port-level checks of the mirror frame rewriter, bound to the top level.
module mfr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mfr_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:64] >= 4'd1 && m_tdata[67:64] <= 4'd8)
        else $error("output count out of range");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'd8)
        else $error("non-final output item not full");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind mirror_frame_rewriter mfr_checker u_mfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
